// ----- sv/bhc_pkg.sv -----
package bhc_pkg;

    // Word widths of the two arithmetic paths
    localparam int W32 = 32;
    localparam int W64 = 64;

    // Restoring divider: one quotient bit per stage
    localparam int DIV_STEPS = 64;

    // Total register stages from input to output register
    localparam int N_STAGES = 86;

    // Temperature constants
    localparam logic signed [31:0] T_MUL   = 32'sd5;
    localparam logic signed [31:0] T_ROUND = 32'sd128;

    // Pressure constants
    localparam logic signed [63:0] P_OFFSET_FINE = 64'sd128000;
    localparam logic signed [63:0] P_ADC_FULL    = 64'sd1048576;
    localparam logic signed [63:0] P_SCALE       = 64'sd3125;
    localparam logic signed [63:0] P_V1_BIAS     = 64'sh0000_8000_0000_0000;

    // Humidity constants
    localparam logic signed [31:0] H_OFFSET_FINE = 32'sd76800;
    localparam logic signed [31:0] H_ROUND_A     = 32'sd16384;
    localparam logic signed [31:0] H_HALF        = 32'sd32768;
    localparam logic signed [31:0] H_BIAS_B      = 32'sd2097152;
    localparam logic signed [31:0] H_ROUND_C     = 32'sd8192;
    localparam logic signed [31:0] H_CLAMP       = 32'sd419430400;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP_P9 = 3'd0,
        CFG_PRESS_LO = 3'd1,
        CFG_PRESS_HI = 3'd2,
        CFG_HUM = 3'd3,
        CFG_HUM_EN = 3'd4
    } t_cfg_idx;

endpackage

// ----- sv/baro_humidity_compensation_top.sv -----
// Channel  Direction  Signals                                      Payload
// in       input      i_in_valid / o_in_stall                      raw pressure, temp, humidity
// out      output     o_out_valid / i_out_stall                    temp, pressure, flag, humidity
// cfg      input      i_cfg_valid / o_cfg_ready, i_cfg_index       64-bit calibration word
//
// One item enters per cycle while no result is held at the output.
// 86 register stages: 15 ahead of the divider, 65 divider registers, 5 after, 1 output.
// Reset clears all calibration registers and the valid bits of every stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// o_cfg_ready is always high; write calibration only while the pipeline is empty.
module baro_humidity_compensation_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [19:0]         i_raw_pressure,
    input  logic [19:0]         i_raw_temperature,
    input  logic [15:0]         i_raw_humidity,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_temperature_centi,
    output logic [31:0]         o_pressure_q24_8,
    output logic                o_pressure_invalid,
    output logic [16:0]         o_humidity_q22_10,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    typedef struct packed {
        logic        neg;
        logic        inv;
        logic [31:0] temp;
        logic [16:0] hum;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
    } t_dv;

    typedef struct packed {
        logic        inv;
        logic [31:0] temp;
        logic [16:0] hum;
        logic [63:0] p;
        logic [63:0] w2;
    } t_post;

    // Configuration registers
    logic [63:0] r_cal_t;
    logic [63:0] r_cal_pl;
    logic [63:0] r_cal_ph;
    logic [63:0] r_cal_h;
    logic        r_hum_en;

    logic [bhc_pkg::N_STAGES-1:0] r_vld;
    logic w_ce;

    // Calibration fields
    logic signed [31:0] w_t1, w_t2, w_t3;
    logic signed [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic signed [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    assign w_t1 = 32'(r_cal_t[15:0]);
    assign w_t2 = 32'($signed(r_cal_t[31:16]));
    assign w_t3 = 32'($signed(r_cal_t[47:32]));
    assign w_p9 = 64'($signed(r_cal_t[63:48]));
    assign w_p1 = 64'(r_cal_pl[15:0]);
    assign w_p2 = 64'($signed(r_cal_pl[31:16]));
    assign w_p3 = 64'($signed(r_cal_pl[47:32]));
    assign w_p4 = 64'($signed(r_cal_pl[63:48]));
    assign w_p5 = 64'($signed(r_cal_ph[15:0]));
    assign w_p6 = 64'($signed(r_cal_ph[31:16]));
    assign w_p7 = 64'($signed(r_cal_ph[47:32]));
    assign w_p8 = 64'($signed(r_cal_ph[63:48]));
    assign w_h1 = 32'(r_cal_h[7:0]);
    assign w_h2 = 32'($signed(r_cal_h[23:8]));
    assign w_h3 = 32'(r_cal_h[31:24]);
    assign w_h4 = 32'($signed(r_cal_h[43:32]));
    assign w_h5 = 32'($signed(r_cal_h[55:44]));
    assign w_h6 = 32'($signed(r_cal_h[63:56]));

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pl <= '0;
            r_cal_ph <= '0;
            r_cal_h  <= '0;
            r_hum_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (bhc_pkg::t_cfg_idx'(i_cfg_index))
                bhc_pkg::CFG_TEMP_P9:  r_cal_t  <= i_cfg_data;
                bhc_pkg::CFG_PRESS_LO: r_cal_pl <= i_cfg_data;
                bhc_pkg::CFG_PRESS_HI: r_cal_ph <= i_cfg_data;
                bhc_pkg::CFG_HUM:      r_cal_h  <= i_cfg_data;
                bhc_pkg::CFG_HUM_EN:   r_hum_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless the output item is held
    assign w_ce = !(r_vld[bhc_pkg::N_STAGES-1] && i_out_stall);
    assign o_in_stall = !w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[bhc_pkg::N_STAGES-2:0], i_in_valid};
        end
    end

    // ---------------- temperature ----------------
    logic [19:0] r1_adcp, r2_adcp, r3_adcp, r4_adcp, r5_adcp, r6_adcp;
    logic [19:0] r7_adcp, r8_adcp, r9_adcp, r10_adcp, r11_adcp, r12_adcp;
    logic [15:0] r1_adch, r2_adch, r3_adch, r4_adch, r5_adch, r6_adch;
    logic signed [31:0] r1_a, r1_b, r2_ma, r2_mb, r3_tv1, r3_mc, r4_tfine;
    logic signed [31:0] n1_a, n1_b, n3_mbs, n4_mcs, n5_t5;
    logic signed [31:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp;
    logic signed [31:0] r11_temp, r12_temp, r13_temp, r14_temp, r15_temp;
    logic signed [63:0] r5_v1;
    logic signed [31:0] r5_x;

    assign n1_a = 32'(i_raw_temperature >> 3) - (w_t1 <<< 1);
    assign n1_b = 32'(i_raw_temperature >> 4) - w_t1;
    assign n3_mbs = r2_mb >>> 12;
    assign n4_mcs = r3_mc >>> 14;
    assign n5_t5 = r4_tfine * bhc_pkg::T_MUL + bhc_pkg::T_ROUND;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_adcp <= i_raw_pressure;
            r1_adch <= i_raw_humidity;
            r1_a <= n1_a;
            r1_b <= n1_b;
            r2_adcp <= r1_adcp;
            r2_adch <= r1_adch;
            r2_ma <= r1_a * w_t2;
            r2_mb <= r1_b * r1_b;
            r3_adcp <= r2_adcp;
            r3_adch <= r2_adch;
            r3_tv1 <= r2_ma >>> 11;
            r3_mc <= n3_mbs * w_t3;
            r4_adcp <= r3_adcp;
            r4_adch <= r3_adch;
            r4_tfine <= r3_tv1 + n4_mcs;
            r5_adcp <= r4_adcp;
            r5_adch <= r4_adch;
            r5_temp <= n5_t5 >>> 8;
            r5_v1 <= 64'(r4_tfine) - bhc_pkg::P_OFFSET_FINE;
            r5_x <= r4_tfine - bhc_pkg::H_OFFSET_FINE;
        end
    end

    // ---------------- humidity ----------------
    logic signed [31:0] r6_mh5, r6_mx6, r6_mx3;
    logic signed [31:0] r7_ha, r7_hbm, r8_ha, r8_hb, r9_ha, r9_hcm, r10_ha, r10_hc;
    logic signed [31:0] r11_x2, r12_x2, r12_hsq, r13_x2, r13_m1;
    logic signed [31:0] n7_hsum, n7_ha, n7_m6s, n7_m3s, n12_xs, n13_sqs, n14_x3;
    logic signed [31:0] n9_hbs, n10_hcs, n14_m1s, n14_clamp;
    logic [16:0] r14_hum, r15_hum, n14_hum;

    assign n7_hsum = 32'({r6_adch, 14'h0}) - (w_h4 <<< 20) - r6_mh5 + bhc_pkg::H_ROUND_A;
    assign n7_ha = n7_hsum >>> 15;
    assign n7_m6s = r6_mx6 >>> 10;
    assign n7_m3s = (r6_mx3 >>> 11) + bhc_pkg::H_HALF;
    assign n9_hbs = r7_hbm >>> 10;
    assign n10_hcs = r9_hcm + bhc_pkg::H_ROUND_C;
    assign n12_xs = r11_x2 >>> 15;
    assign n13_sqs = r12_hsq >>> 7;
    assign n14_m1s = r13_m1 >>> 4;
    assign n14_x3 = r13_x2 - n14_m1s;

    // Clamp to 0..100 %RH before dropping the 12 fraction bits
    always_comb begin
        if (n14_x3 < 0) begin
            n14_clamp = '0;
        end else if (n14_x3 > bhc_pkg::H_CLAMP) begin
            n14_clamp = bhc_pkg::H_CLAMP;
        end else begin
            n14_clamp = n14_x3;
        end
        n14_hum = r_hum_en ? n14_clamp[28:12] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r6_mh5 <= w_h5 * r5_x;
            r6_mx6 <= r5_x * w_h6;
            r6_mx3 <= r5_x * w_h3;
            r7_ha <= n7_ha;
            r7_hbm <= n7_m6s * n7_m3s;
            r8_ha <= r7_ha;
            r8_hb <= n9_hbs + bhc_pkg::H_BIAS_B;
            r9_ha <= r8_ha;
            r9_hcm <= r8_hb * w_h2;
            r10_ha <= r9_ha;
            r10_hc <= n10_hcs >>> 14;
            r11_x2 <= r10_ha * r10_hc;
            r12_x2 <= r11_x2;
            r12_hsq <= n12_xs * n12_xs;
            r13_x2 <= r12_x2;
            r13_m1 <= n13_sqs * w_h1;
            r14_hum <= n14_hum;
            r15_hum <= r14_hum;
        end
    end

    // ---------------- pressure, ahead of the divider ----------------
    logic [63:0] w_sq, w_m5, w_m2, w_m6, w_m3, w_v1c, w_num;
    logic signed [63:0] r8_m5s, r8_m2s, r9_m5s, r9_m2s, r10_v2, r10_v1b;
    logic signed [63:0] r11_v2, r12_v2, r13_den, r13_num0, r14_den, r15_den;
    logic signed [63:0] n10_m3s, n13_v1c, n13_pp;

    bhc_mul64 u_mul_sq (.i_clk, .i_ce(w_ce), .i_a(r5_v1), .i_b(r5_v1), .o_p(w_sq));
    bhc_mul64 u_mul_m5 (.i_clk, .i_ce(w_ce), .i_a(r5_v1), .i_b(w_p5), .o_p(w_m5));
    bhc_mul64 u_mul_m2 (.i_clk, .i_ce(w_ce), .i_a(r5_v1), .i_b(w_p2), .o_p(w_m2));
    bhc_mul64 u_mul_m6 (.i_clk, .i_ce(w_ce), .i_a(w_sq), .i_b(w_p6), .o_p(w_m6));
    bhc_mul64 u_mul_m3 (.i_clk, .i_ce(w_ce), .i_a(w_sq), .i_b(w_p3), .o_p(w_m3));
    bhc_mul64 u_mul_v1c (
        .i_clk, .i_ce(w_ce), .i_a(bhc_pkg::P_V1_BIAS + r10_v1b), .i_b(w_p1), .o_p(w_v1c)
    );
    bhc_mul64 u_mul_num (
        .i_clk, .i_ce(w_ce), .i_a(r13_num0), .i_b(bhc_pkg::P_SCALE), .o_p(w_num)
    );

    assign n10_m3s = $signed(w_m3) >>> 8;
    assign n13_v1c = $signed(w_v1c) >>> 33;
    assign n13_pp = bhc_pkg::P_ADC_FULL - 64'(r12_adcp);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r6_adcp <= r5_adcp;  r6_adch <= r5_adch;  r6_temp <= r5_temp;
            r7_adcp <= r6_adcp;  r7_temp <= r6_temp;
            r8_adcp <= r7_adcp;  r8_temp <= r7_temp;
            r8_m5s <= $signed(w_m5) <<< 17;
            r8_m2s <= $signed(w_m2) <<< 12;
            r9_adcp <= r8_adcp;  r9_temp <= r8_temp;
            r9_m5s <= r8_m5s;
            r9_m2s <= r8_m2s;
            r10_adcp <= r9_adcp; r10_temp <= r9_temp;
            r10_v2 <= $signed(w_m6) + r9_m5s + (w_p4 <<< 35);
            r10_v1b <= n10_m3s + r9_m2s;
            r11_adcp <= r10_adcp; r11_temp <= r10_temp; r11_v2 <= r10_v2;
            r12_adcp <= r11_adcp; r12_temp <= r11_temp; r12_v2 <= r11_v2;
            r13_temp <= r12_temp;
            r13_den <= n13_v1c;
            r13_num0 <= (n13_pp <<< 31) - r12_v2;
            r14_temp <= r13_temp; r14_den <= r13_den;
            r15_temp <= r14_temp; r15_den <= r14_den;
        end
    end

    // ---------------- divider: magnitudes, one bit per stage ----------------
    t_dv r_dv [0:bhc_pkg::DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dv[0].neg  <= w_num[63] ^ r15_den[63];
            r_dv[0].inv  <= (r15_den == '0);
            r_dv[0].temp <= r15_temp;
            r_dv[0].hum  <= r15_hum;
            r_dv[0].rem  <= '0;
            r_dv[0].quo  <= w_num[63] ? (64'h0 - w_num) : w_num;
            r_dv[0].den  <= r15_den[63] ? (64'h0 - r15_den) : r15_den;
        end
    end

    for (genvar k = 1; k <= bhc_pkg::DIV_STEPS; k++) begin : g_div
        logic [64:0] w_rr;
        logic [64:0] w_df;

        assign w_rr = {r_dv[k-1].rem, r_dv[k-1].quo[63]};
        assign w_df = w_rr - {1'b0, r_dv[k-1].den};

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dv[k].neg  <= r_dv[k-1].neg;
                r_dv[k].inv  <= r_dv[k-1].inv;
                r_dv[k].temp <= r_dv[k-1].temp;
                r_dv[k].hum  <= r_dv[k-1].hum;
                r_dv[k].den  <= r_dv[k-1].den;
                r_dv[k].rem  <= w_df[64] ? w_rr[63:0] : w_df[63:0];
                r_dv[k].quo  <= {r_dv[k-1].quo[62:0], !w_df[64]};
            end
        end
    end

    // ---------------- pressure, after the divider ----------------
    t_post r_post [0:4];
    logic [63:0] w_sqp, w_m8, w_w1m;
    logic signed [63:0] n_ps, n_w1, n_sum, n_fin;
    logic [63:0] n_q;

    assign n_q = r_dv[bhc_pkg::DIV_STEPS].neg ? (64'h0 - r_dv[bhc_pkg::DIV_STEPS].quo)
                                             : r_dv[bhc_pkg::DIV_STEPS].quo;
    assign n_ps = $signed(r_post[0].p) >>> 13;

    bhc_mul64 u_mul_sqp (.i_clk, .i_ce(w_ce), .i_a(n_ps), .i_b(n_ps), .o_p(w_sqp));
    bhc_mul64 u_mul_m8 (.i_clk, .i_ce(w_ce), .i_a(w_p8), .i_b(r_post[0].p), .o_p(w_m8));
    bhc_mul64 u_mul_w1 (.i_clk, .i_ce(w_ce), .i_a(w_sqp), .i_b(w_p9), .o_p(w_w1m));

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_post[0].inv  <= r_dv[bhc_pkg::DIV_STEPS].inv;
            r_post[0].temp <= r_dv[bhc_pkg::DIV_STEPS].temp;
            r_post[0].hum  <= r_dv[bhc_pkg::DIV_STEPS].hum;
            r_post[0].p    <= n_q;
            r_post[0].w2   <= '0;
            r_post[1] <= r_post[0];
            r_post[2] <= r_post[1];
            r_post[3].inv  <= r_post[2].inv;
            r_post[3].temp <= r_post[2].temp;
            r_post[3].hum  <= r_post[2].hum;
            r_post[3].p    <= r_post[2].p;
            r_post[3].w2   <= $signed(w_m8) >>> 19;
            r_post[4] <= r_post[3];
        end
    end

    assign n_w1 = $signed(w_w1m) >>> 25;
    assign n_sum = $signed(r_post[4].p) + n_w1 + $signed(r_post[4].w2);
    assign n_fin = (n_sum >>> 8) + (w_p7 <<< 4);

    // Output register
    logic signed [31:0] r_out_temp;
    logic [31:0] r_out_press;
    logic r_out_inv;
    logic [16:0] r_out_hum;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_temp  <= r_post[4].temp;
            r_out_press <= r_post[4].inv ? 32'h0 : n_fin[31:0];
            r_out_inv   <= r_post[4].inv;
            r_out_hum   <= r_post[4].hum;
        end
    end

    assign o_out_valid = r_vld[bhc_pkg::N_STAGES-1];
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_q24_8 = r_out_press;
    assign o_pressure_invalid = r_out_inv;
    assign o_humidity_q22_10 = r_out_hum;

endmodule

// ----- sv/bhc_mul64.sv -----
// Low 64 bits of a 64 x 64 product in two stages:
// three 32 x 32 partial products, then the sum.
module bhc_mul64 (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic [bhc_pkg::W64-1:0]  i_a,
    input  logic [bhc_pkg::W64-1:0]  i_b,
    output logic [bhc_pkg::W64-1:0]  o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_x1;
    logic [31:0] r_x2;
    logic [63:0] r_p;
    logic [63:0] n_p;

    // Partial products; the high x high term falls outside 64 bits
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ll <= {32'h0, i_a[31:0]} * {32'h0, i_b[31:0]};
            r_x1 <= i_a[63:32] * i_b[31:0];
            r_x2 <= i_a[31:0] * i_b[63:32];
        end
    end

    assign n_p = r_ll + {r_x1 + r_x2, 32'h0};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- sv/bhc_checker.sv -----
module bhc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic signed [31:0]  o_temperature_centi,
    input logic [31:0]         o_pressure_q24_8,
    input logic                o_pressure_invalid,
    input logic [16:0]         o_humidity_q22_10
);

    // Held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pressure_q24_8)
            && $stable(o_temperature_centi) && $stable(o_humidity_q22_10))
        else $error("output item changed while stalled");

    // Input is stalled only behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // Zero divisor forces pressure to zero
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pressure_invalid |-> o_pressure_q24_8 == 32'h0)
        else $error("invalid pressure is not zero");

    // Humidity never exceeds 100 %RH
    a_hum_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind baro_humidity_compensation_top bhc_checker u_bhc_checker (.*);
